[rtl/saa_pkg.sv]
`timescale 1ns / 1ps

package saa_pkg;

  localparam int unsigned DimW      = 14;
  localparam int unsigned PpuW      = 11;
  localparam int unsigned AtlasW    = 15;
  localparam int unsigned TopW      = 16;
  localparam int unsigned RowW      = 17;
  localparam int unsigned HeightW   = 15;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 15;
  localparam int unsigned DivSteps  = DimW;
  localparam int unsigned DivCntW   = 4;

  localparam logic [RowW-1:0] RowMax = {RowW{1'b1}};

  localparam logic [CfgIdxW-1:0] CFG_ATLAS_WIDTH     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PIXELS_PER_UNIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_VERTICAL_LIMIT  = 2'd2;

  localparam logic [AtlasW-1:0] ATLAS_WIDTH_RST     = 15'd4096;
  localparam logic [PpuW-1:0]   PIXELS_PER_UNIT_RST = 11'd16;
  localparam logic [AtlasW-1:0] VERTICAL_LIMIT_RST  = 15'd4096;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic clr_we;    // clear one shelf entry
    logic load;      // capture request, start division
    logic div_step;  // one quotient bit
    logic chk;       // compute shelf height, read shelf entry
    logic prep;      // compute row for a fresh shelf
    logic upd;       // place sprite, write back, emit result
    logic emit_fail; // emit fail result, no state change
  } saa_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic cls_oob;
  } saa_sts_t;

  typedef struct packed {
    logic              open;
    logic [TopW-1:0]   top;
    logic [AtlasW-1:0] fill;
  } shelf_entry_t;

endpackage

[rtl/saa_div.sv]
`timescale 1ns / 1ps

module saa_div import saa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            step_i,
  input  logic [DimW-1:0] dividend_i,
  input  logic [PpuW-1:0] divisor_i,
  output logic            last_o,
  output logic [DimW-1:0] quo_o,
  output logic [PpuW-1:0] rem_o
);

  logic [DimW-1:0]    quo_q, quo_d;
  logic [PpuW-1:0]    rem_q, rem_d;
  logic [PpuW-1:0]    div_q;
  logic [DivCntW-1:0] cnt_q;
  logic [PpuW:0]      rem_sh;
  logic [PpuW+1:0]    diff;
  logic               ge;

  // Restoring division, one quotient bit per step.
  always_comb begin
    rem_sh = {rem_q, quo_q[DimW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, div_q};
    ge     = ~diff[PpuW+1];
    rem_d  = ge ? diff[PpuW-1:0] : rem_sh[PpuW-1:0];
    quo_d  = {quo_q[DimW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (step_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign last_o = (cnt_q == DivCntW'(DivSteps - 1));
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

[rtl/saa_datapath.sv]
`timescale 1ns / 1ps

module saa_datapath import saa_pkg::*; #(
  parameter int unsigned MAX_SHELVES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  saa_cmd_t            cmd_i,
  output saa_sts_t            sts_o,
  input  logic [DimW-1:0]     sprite_width_i,
  input  logic [DimW-1:0]     sprite_height_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                done_o,
  output logic                status_o,
  output logic [AtlasW-1:0]   visible_x_o,
  output logic [TopW-1:0]     visible_y_o
);

  localparam int unsigned IdxW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;

  logic [AtlasW-1:0]  atlas_width_q;
  logic [PpuW-1:0]    ppu_q;
  logic [AtlasW-1:0]  vlimit_q;

  logic [PpuW-1:0]    ppu_eff;
  logic [DimW-1:0]    dividend;
  logic [DimW-1:0]    quo;
  logic [PpuW-1:0]    rem;
  logic               div_last;

  logic [AtlasW-1:0]  pw_q;
  logic [DimW-1:0]    dvd_q;
  logic [PpuW-1:0]    ppu_used_q;
  logic [HeightW-1:0] height_q;
  logic [RowW-1:0]    nfr_q, nfr_d;
  logic [RowW-1:0]    row_q;
  logic [RowW:0]      row_sum;
  logic [IdxW-1:0]    idx;
  logic [IdxW-1:0]    clr_cnt_q;

  shelf_entry_t       mem_q [MAX_SHELVES];
  shelf_entry_t       rd_q;
  shelf_entry_t       wr_data;
  logic [IdxW-1:0]    wr_addr;
  logic               wr_en;

  logic [AtlasW:0]    fill_sum;
  logic               fresh;
  logic [AtlasW-1:0]  x_sel;
  logic [TopW-1:0]    y_sel;
  logic [AtlasW:0]    next_fill;
  logic               fail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_width_q <= ATLAS_WIDTH_RST;
      ppu_q         <= PIXELS_PER_UNIT_RST;
      vlimit_q      <= VERTICAL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ATLAS_WIDTH:     atlas_width_q <= cfg_wdata_i;
        CFG_PIXELS_PER_UNIT: ppu_q         <= cfg_wdata_i[PpuW-1:0];
        CFG_VERTICAL_LIMIT:  vlimit_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign ppu_eff  = (ppu_q == '0) ? PpuW'(1) : ppu_q;
  assign dividend = (sprite_height_i == '0) ? '0 : sprite_height_i - DimW'(1);

  saa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.load),
    .step_i     (cmd_i.div_step),
    .dividend_i (dividend),
    .divisor_i  (ppu_eff),
    .last_o     (div_last),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  assign idx = quo[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pw_q       <= {1'b0, sprite_width_i} + AtlasW'(2);
      dvd_q      <= dividend;
      ppu_used_q <= ppu_eff;
    end
    // ppu * (cls + 1) equals dividend - remainder + ppu
    if (cmd_i.chk) begin
      height_q <= HeightW'(dvd_q - {3'b000, rem}) + HeightW'(ppu_used_q) + HeightW'(2);
    end
    if (cmd_i.prep) begin
      row_q <= row_sum[RowW] ? RowMax : row_sum[RowW-1:0];
    end
  end

  assign row_sum = {1'b0, nfr_q} + (RowW+1)'(height_q) + (RowW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_cnt_q <= clr_cnt_q + IdxW'(1);
    end
  end

  // Placement decision on the entry read out of shelf memory.
  always_comb begin
    fill_sum  = {1'b0, rd_q.fill} + {1'b0, pw_q};
    fresh     = ~rd_q.open || (fill_sum >= {1'b0, atlas_width_q});
    x_sel     = fresh ? '0 : rd_q.fill;
    y_sel     = fresh ? nfr_q[TopW-1:0] : rd_q.top;
    nfr_d     = fresh ? row_q : nfr_q;
    next_fill = {1'b0, x_sel} + {1'b0, pw_q};
    fail      = nfr_d > {2'b00, vlimit_q};
  end

  always_comb begin
    wr_en   = cmd_i.clr_we | cmd_i.upd;
    wr_addr = cmd_i.clr_we ? clr_cnt_q : idx;
    if (cmd_i.clr_we) begin
      wr_data = '0;
    end else begin
      wr_data.open = 1'b1;
      wr_data.top  = y_sel;
      wr_data.fill = next_fill[AtlasW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.chk) begin
      rd_q <= mem_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nfr_q  <= '0;
      done_o <= 1'b0;
    end else begin
      if (cmd_i.upd) begin
        nfr_q <= nfr_d;
      end
      done_o <= cmd_i.upd | cmd_i.emit_fail;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_fail || (cmd_i.upd && fail)) begin
      status_o    <= STATUS_FAIL;
      visible_x_o <= '0;
      visible_y_o <= '0;
    end else if (cmd_i.upd) begin
      status_o    <= STATUS_OK;
      visible_x_o <= x_sel + AtlasW'(1);
      visible_y_o <= y_sel + TopW'(1);
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == IdxW'(MAX_SHELVES - 1));
  assign sts_o.div_last = div_last;
  assign sts_o.cls_oob  = ({1'b0, quo} >= (DimW+1)'(MAX_SHELVES));

endmodule

[rtl/saa_ctrl.sv]
`timescale 1ns / 1ps

module saa_ctrl import saa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  saa_sts_t sts_i,
  output saa_cmd_t cmd_o,
  output logic     busy_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_UPDATE = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.cls_oob) begin
          cmd_o.emit_fail = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.chk = 1'b1;
          state_d   = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[rtl/shelf_atlas_allocator_core.sv]
`timescale 1ns / 1ps

// Shelf packing allocator for sprites in a texture atlas.
// Request: raise start_i with sprite_width_i and sprite_height_i; the
// transaction is taken at a clock edge where start_i is high and busy_o low.
// Result: done_o is high for exactly one cycle with status_o, visible_x_o and
// visible_y_o. The receiver cannot stall; a result is gone after that cycle.
// Sequence: a 14-step restoring divider finds the height class, then a class
// check with the shelf memory read, a row step and an update; done_o follows
// the update, or the class check when the height class is out of range. A new
// request may be taken at the edge that ends the done_o cycle.
// Configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i write atlas_width (0),
// pixels_per_unit (1), vertical_limit (2); write only when idle.
// Reset: registers return to 4096/16/4096, next free row to 0, then a
// clearing pass over all MAX_SHELVES entries marks every shelf closed; busy_o
// stays high during the pass.
module shelf_atlas_allocator_core import saa_pkg::*; #(
  parameter int unsigned MAX_SHELVES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [DimW-1:0]     sprite_width_i,
  input  logic [DimW-1:0]     sprite_height_i,
  output logic                done_o,
  output logic                status_o,
  output logic [AtlasW-1:0]   visible_x_o,
  output logic [TopW-1:0]     visible_y_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  saa_cmd_t cmd;
  saa_sts_t sts;

  saa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  saa_datapath #(
    .MAX_SHELVES (MAX_SHELVES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sprite_width_i  (sprite_width_i),
    .sprite_height_i (sprite_height_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .visible_x_o     (visible_x_o),
    .visible_y_o     (visible_y_o)
  );

endmodule

[rtl/saa_checker.sv]
`timescale 1ns / 1ps

module saa_checker import saa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input logic              status_o,
  input logic [AtlasW-1:0] visible_x_o,
  input logic [TopW-1:0]   visible_y_o
);

  // An accepted transaction occupies the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accept did not make the block busy");

  // Results are single-cycle strobes, never back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

  // A result only follows a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without a transaction in flight");

  // Failed allocations report a zero origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STATUS_FAIL)) |-> ((visible_x_o == '0) && (visible_y_o == '0)))
    else $error("fail result carries a nonzero origin");

endmodule

bind shelf_atlas_allocator_core saa_checker u_saa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .status_o    (status_o),
  .visible_x_o (visible_x_o),
  .visible_y_o (visible_y_o)
);

[sim/shelf_atlas_allocator_core_test.sv]
`timescale 1ns / 1ps

module shelf_atlas_allocator_core_test;
  import saa_pkg::*;

  localparam int unsigned ShelfCount = 64;
  localparam int unsigned StallLimit = 5000;

  typedef struct packed {
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
  } sprite_req_t;

  typedef struct packed {
    logic              status;
    logic [AtlasW-1:0] x;
    logic [TopW-1:0]   y;
  } placement_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [DimW-1:0]     sprite_width_i = '0;
  logic [DimW-1:0]     sprite_height_i = '0;
  logic                done_o;
  logic                status_o;
  logic [AtlasW-1:0]   visible_x_o;
  logic [TopW-1:0]     visible_y_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  shelf_atlas_allocator_core #(
    .MAX_SHELVES(ShelfCount)
  ) i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Allocator state as the block should hold it.
  int unsigned atlas_w_m = ATLAS_WIDTH_RST;
  int unsigned ppu_m = PIXELS_PER_UNIT_RST;
  int unsigned vlimit_m = VERTICAL_LIMIT_RST;
  bit          shelf_open_m[ShelfCount];
  int unsigned shelf_top_m[ShelfCount];
  int unsigned shelf_fill_m[ShelfCount];
  int unsigned next_row_m = 0;

  sprite_req_t request_q[$];
  placement_t  placement_q[$];
  sprite_req_t cur_req;
  int unsigned gap_cnt = 0;
  logic        steady = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;

  function automatic placement_t place_sprite(sprite_req_t r);
    int unsigned pw, p, cls, hgt, row, x, y;
    placement_t res;
    res = '{status: STATUS_FAIL, x: '0, y: '0};
    pw = int'(r.w) + 2;
    p = (ppu_m == 0) ? 1 : ppu_m;
    cls = (r.h == 0) ? 0 : (int'(r.h) - 1) / p;
    if (cls >= ShelfCount) return res;
    hgt = p * (cls + 1) + 2;
    if (!shelf_open_m[cls] || shelf_fill_m[cls] + pw >= atlas_w_m) begin
      shelf_open_m[cls] = 1'b1;
      shelf_top_m[cls] = next_row_m & 32'hFFFF;
      shelf_fill_m[cls] = 0;
      row = next_row_m + hgt + 1;
      next_row_m = (row > RowMax) ? RowMax : row;
    end
    x = shelf_fill_m[cls];
    y = shelf_top_m[cls];
    shelf_fill_m[cls] = (x + pw) & 32'h7FFF;
    if (next_row_m > vlimit_m) return res;
    res.status = STATUS_OK;
    res.x = AtlasW'(x + 1);
    res.y = TopW'(y + 1);
    return res;
  endfunction

  function automatic sprite_req_t random_sprite();
    int unsigned sel, wlim, hlim, p;
    sprite_req_t r;
    p = (ppu_m == 0) ? 1 : ppu_m;
    sel = $urandom_range(0, 99);
    if (sel < 80) wlim = atlas_w_m / 8;
    else if (sel < 90) wlim = atlas_w_m;
    else wlim = 16383;
    if (wlim < 2) wlim = 2;
    if (wlim > 16383) wlim = 16383;
    sel = $urandom_range(0, 99);
    if (sel < 70) hlim = 8 * p;
    else if (sel < 90) hlim = 65 * p;
    else hlim = 16383;
    if (hlim > 16383) hlim = 16383;
    r.w = DimW'($urandom_range(0, wlim));
    r.h = DimW'($urandom_range(0, hlim));
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic push_sprite(input int unsigned w, input int unsigned h);
    request_q.push_back('{w: DimW'(w), h: DimW'(h)});
  endtask

  task automatic queue_random_sprites(input int unsigned n);
    repeat (n) request_q.push_back(random_sprite());
  endtask

  // Hold until every request is taken and answered and the block is idle.
  task automatic wait_idle();
    while (request_q.size() != 0 || placement_q.size() != 0 || start_i || busy_o)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] aw, input logic [CfgDataW-1:0] ppu,
                              input logic [CfgDataW-1:0] vl);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_ATLAS_WIDTH;
    cfg_wdata_i <= aw;
    @(posedge clk_i);
    cfg_idx_i <= CFG_PIXELS_PER_UNIT;
    cfg_wdata_i <= ppu;
    @(posedge clk_i);
    cfg_idx_i <= CFG_VERTICAL_LIMIT;
    cfg_wdata_i <= vl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    atlas_w_m = aw;
    ppu_m = ppu[PpuW-1:0];
    vlimit_m = vl;
  endtask

  // Driver: one transaction per accepted start, random gaps between them outside the steady phase.
  always @(posedge clk_i) begin
    logic nxt_start;
    if (rst_ni) begin
      nxt_start = start_i;
      if (start_i && !busy_o) begin
        placement_q.push_back(place_sprite(cur_req));
        nxt_start = 1'b0;
        gap_cnt = (!steady && $urandom_range(0, 99) < 26) ? $urandom_range(1, 46) : 0;
      end
      if (!nxt_start) begin
        if (gap_cnt != 0) gap_cnt--;
        else if (request_q.size() != 0) begin
          cur_req = request_q.pop_front();
          nxt_start = 1'b1;
        end
      end
      start_i <= nxt_start;
      if (nxt_start) begin
        sprite_width_i <= cur_req.w;
        sprite_height_i <= cur_req.h;
      end else begin
        sprite_width_i <= DimW'($urandom_range(0, 16383));
        sprite_height_i <= DimW'($urandom_range(0, 16383));
      end
    end
  end

  // Monitor: results cannot be held off, check each one as it passes.
  always @(posedge clk_i) begin
    placement_t want;
    if (rst_ni && done_o) begin
      if (placement_q.size() == 0) begin
        flag_mismatch("result with no transaction pending");
      end else begin
        want = placement_q.pop_front();
        if (status_o !== want.status)
          flag_mismatch($sformatf("status %0b, expected %0b", status_o, want.status));
        if (visible_x_o !== want.x)
          flag_mismatch($sformatf("visible_x %0d, expected %0d", visible_x_o, want.x));
        if (visible_y_o !== want.y)
          flag_mismatch($sformatf("visible_y %0d, expected %0d", visible_y_o, want.y));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("shelf_atlas_allocator_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned vl;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: class edges, wide sprites, shelf overflow, out of room.
    push_sprite(0, 0);
    push_sprite(16383, 16383);
    push_sprite(1, 1);
    push_sprite(5, 16);
    push_sprite(5, 17);
    push_sprite(100, 1024);
    push_sprite(100, 1025);
    push_sprite(16383, 5);
    push_sprite(16383, 5);
    push_sprite(4085, 20);
    push_sprite(0, 20);
    push_sprite(8191, 8192);
    repeat (4) push_sprite(16383, 1024);
    push_sprite(0, 17);
    push_sprite(3, 33);
    wait_idle();

    program_regs(15'd3000, 15'd16, 15'd32767);
    queue_random_sprites(350);
    wait_idle();

    // Every request within the class range opens a shelf.
    program_regs(15'd1, 15'd1, 15'd32767);
    queue_random_sprites(100);
    wait_idle();

    // Zero width and zero granularity.
    program_regs(15'd0, 15'd0, 15'd32767);
    push_sprite(7, 64);
    push_sprite(7, 65);
    queue_random_sprites(60);
    wait_idle();

    steady <= 1'b1;
    program_regs(15'd32767, 15'd5, 15'd32767);
    queue_random_sprites(300);
    wait_idle();
    steady <= 1'b0;

    // Limit of one: all fail, state still advances.
    program_regs(15'd4096, 15'd16, 15'd1);
    queue_random_sprites(60);
    wait_idle();

    // Limit just ahead of the next free row, so it gets crossed in this phase.
    vl = next_row_m + 300;
    if (vl > 32767) vl = 32767;
    program_regs(15'd500, 15'd3, CfgDataW'(vl));
    queue_random_sprites(300);
    wait_idle();

    program_regs(15'd4096, 15'd1024, 15'd32767);
    queue_random_sprites(60);
    wait_idle();

    // Upper data bits above the granularity field drop; drive the row to saturation.
    program_regs(15'd0, 15'h7FFF, 15'd32767);
    repeat (8) push_sprite($urandom_range(0, 16383), 16383);
    queue_random_sprites(40);
    wait_idle();

    if (mismatch_cnt == 0)
      $display("shelf_atlas_allocator_core test passed");
    else
      $display("shelf_atlas_allocator_core test failed");
    $finish;
  end

endmodule
